>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// shared constants, types and tables of the uv sphere vertex generator
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int SEG_W           = 11;
    localparam int MAX_SEGMENTS    = 1024;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STAGES   =
        (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
    localparam int DIV_W           = 42;
    localparam int DIV_STAGES      = DIV_W;

    localparam logic [31:0]        PI_Q30          = 32'd3373259426;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic [2:0] REG_LON_SEGMENTS = 3'd0;
    localparam logic [2:0] REG_LAT_SEGMENTS = 3'd1;
    localparam logic [2:0] REG_CENTER_X     = 3'd2;
    localparam logic [2:0] REG_CENTER_Y     = 3'd3;
    localparam logic [2:0] REG_CENTER_Z     = 3'd4;
    localparam logic [2:0] REG_RADIUS       = 3'd5;

    typedef struct packed {
        logic [SEG_W-1:0] rem;
        logic [DIV_W-1:0] dq;
    } t_div_lane;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } t_rot;

    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        logic [29:0] v;
        unique case (k)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic [SEG_W-1:0] seg_count(input logic [SEG_W-1:0] v);
        logic [SEG_W-1:0] r;
        if (v == '0) begin
            r = SEG_W'(1);
        end else if (v > SEG_W'(MAX_SEGMENTS)) begin
            r = SEG_W'(MAX_SEGMENTS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell
// one bit of a pipelined long division, two lanes (theta and phi phase)
// ----------------------------------------------------------------------------
module uvs_div_cell
    import uvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SEG_W-1:0] i_n,
    input  logic [SEG_W-1:0] i_m,
    input  t_div_lane        i_th,
    input  t_div_lane        i_ph,
    output logic             o_valid,
    output t_div_lane        o_th,
    output t_div_lane        o_ph
);

    function automatic t_div_lane f_step(input t_div_lane l, input logic [SEG_W-1:0] d);
        logic [SEG_W:0] t;
        t_div_lane      r;
        t = {l.rem, l.dq[DIV_W-1]};
        if (t >= {1'b0, d}) begin
            r.rem = SEG_W'(t - {1'b0, d});
            r.dq  = {l.dq[DIV_W-2:0], 1'b1};
        end else begin
            r.rem = t[SEG_W-1:0];
            r.dq  = {l.dq[DIV_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic      r_valid;
    t_div_lane r_th, r_ph;
    t_div_lane n_th, n_ph;

    always_comb begin
        n_th = f_step(i_th, i_n);
        n_ph = f_step(i_ph, i_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th <= n_th;
            r_ph <= n_ph;
        end
    end

    assign o_valid = r_valid;
    assign o_th    = r_th;
    assign o_ph    = r_ph;

endmodule

>>> rtl/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// one rotation-mode cordic step for the theta and phi angles
// ----------------------------------------------------------------------------
module uvs_cordic_cell
    import uvs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [4:0] i_k,
    input  t_rot       i_th,
    input  t_rot       i_ph,
    output logic       o_valid,
    output t_rot       o_th,
    output t_rot       o_ph
);

    function automatic t_rot f_rot(input t_rot a, input logic [4:0] k);
        logic signed [33:0] xs, ys;
        logic signed [32:0] at;
        t_rot               r;
        xs = a.x >>> k;
        ys = a.y >>> k;
        at = $signed({3'b000, atan_q30(k)});
        if (!a.z[32]) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - at;
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + at;
        end
        return r;
    endfunction

    logic r_valid;
    t_rot r_th, r_ph;
    t_rot n_th, n_ph;

    always_comb begin
        n_th = f_rot(i_th, i_k);
        n_ph = f_rot(i_ph, i_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th <= n_th;
            r_ph <= n_ph;
        end
    end

    assign o_valid = r_valid;
    assign o_th    = r_th;
    assign o_ph    = r_ph;

endmodule

>>> rtl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// vertex, normal, texture coordinate and quad corners of one sphere grid point
// ----------------------------------------------------------------------------
// input beat: longitude and latitude index on s_tdata; output beat: one vertex
// on m_tdata. mesh size, center and radius sit in apb registers, to be written
// while the block is idle (the block does not enforce this); pready is tied high.
// the data path is a row of cells: an entry stage, 42 long division cells
// give both angle phases and the texture coordinates, an angle stage, 16
// cordic cells give sine and cosine, then clamp and quadrant, two multiply
// stages with normal rounding between them, and the position add with
// saturation. one beat per cycle is accepted while the skid entry is empty;
// every cell advances each cycle unless the row holds.
// the output register is backed by one skid entry, so a beat is still taken
// while a result waits; once the skid entry fills the whole row holds and
// s_tready drops until the receiver takes the waiting beat.
// reset empties the row and the output and loads the register defaults
// (32 by 16 segments, center zero, radius one).
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core
    import uvs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lon_index[9:0], lat_index[20:10]
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
    // corner_a, corner_b, corner_c, corner_d
    output logic [263:0] m_tdata
);

    typedef struct packed {
        logic [20:0] d;
        logic [20:0] c;
        logic [20:0] b;
        logic [20:0] a;
    } t_corners;

    typedef struct packed {
        t_corners    corn;
        logic [16:0] v;
        logic [16:0] u;
        logic [1:0]  qth;
        logic [1:0]  qph;
    } t_tail;

    typedef struct packed {
        logic [20:0]        corner_d;
        logic [20:0]        corner_c;
        logic [20:0]        corner_b;
        logic [20:0]        corner_a;
        logic [16:0]        tex_v;
        logic [16:0]        tex_u;
        logic signed [15:0] norm_z;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_sc;

    // configuration registers
    logic [SEG_W-1:0]   r_lon, r_lat;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lon <= SEG_W'(32);
            r_lat <= SEG_W'(16);
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= 31'd65536;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_LON_SEGMENTS: r_lon <= pwdata[SEG_W-1:0];
                REG_LAT_SEGMENTS: r_lat <= pwdata[SEG_W-1:0];
                REG_CENTER_X:     r_cx  <= pwdata;
                REG_CENTER_Y:     r_cy  <= pwdata;
                REG_CENTER_Z:     r_cz  <= pwdata;
                REG_RADIUS:       r_rad <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_LON_SEGMENTS: prdata = {21'b0, r_lon};
            REG_LAT_SEGMENTS: prdata = {21'b0, r_lat};
            REG_CENTER_X:     prdata = r_cx;
            REG_CENTER_Y:     prdata = r_cy;
            REG_CENTER_Z:     prdata = r_cz;
            REG_RADIUS:       prdata = {1'b0, r_rad};
            default:          prdata = '0;
        endcase
    end

    logic [SEG_W-1:0] w_n, w_m;
    assign w_n = seg_count(r_lon);
    assign w_m = seg_count(r_lat);

    // pipeline hold
    logic r_out_valid, r_skid_valid;
    logic w_en;
    assign w_en     = ~r_skid_valid;
    assign s_tready = w_en;

    // entry stage: corners and division setup
    logic [9:0]  w_i;
    logic [10:0] w_j;
    logic [21:0] w_nj;
    logic [20:0] w_a, w_b, w_c, w_d;
    logic        w_last;
    t_corners    n_corn0;

    assign w_i = s_tdata[9:0];
    assign w_j = s_tdata[20:10];

    always_comb begin
        w_nj   = 22'(w_n) * 22'(w_j);
        w_last = ({1'b0, w_i} == (w_n - SEG_W'(1)));
        w_a    = 21'(w_nj + 22'(w_i));
        w_c    = 21'(w_a + 21'(w_n));
        w_b    = w_last ? w_nj[20:0] : 21'(w_a + 21'd1);
        w_d    = w_last ? 21'(w_nj + 22'(w_n)) : 21'(w_c + 21'd1);
        if (w_j >= w_m) begin
            n_corn0 = '0;
        end else begin
            n_corn0 = '{d: w_d, c: w_c, b: w_b, a: w_a};
        end
    end

    logic      r_v0;
    t_corners  r_corn0;
    t_div_lane r_th0, r_ph0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_corn0   <= n_corn0;
            r_th0.rem <= '0;
            r_th0.dq  <= {w_i, 32'b0};
            r_ph0.rem <= '0;
            r_ph0.dq  <= {w_j, 31'b0};
        end
    end

    // division row
    logic      w_dv  [DIV_STAGES+1];
    t_div_lane w_dth [DIV_STAGES+1];
    t_div_lane w_dph [DIV_STAGES+1];
    t_corners  r_cs  [DIV_STAGES];

    assign w_dv[0]  = r_v0;
    assign w_dth[0] = r_th0;
    assign w_dph[0] = r_ph0;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        uvs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[g]),
            .i_n     (w_n),
            .i_m     (w_m),
            .i_th    (w_dth[g]),
            .i_ph    (w_dph[g]),
            .o_valid (w_dv[g+1]),
            .o_th    (w_dth[g+1]),
            .o_ph    (w_dph[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cs[g] <= (g == 0) ? r_corn0 : r_cs[(g == 0) ? 0 : g-1];
            end
        end
    end

    // angle stage: phase to radians
    logic [DIV_W-1:0] w_qth, w_qph;
    logic [31:0]      w_pth, w_pph;
    logic [61:0]      w_zth, w_zph;
    logic [25:0]      w_u26;
    logic [26:0]      w_v27;
    t_tail            n_tail0;

    always_comb begin
        w_qth        = w_dth[DIV_STAGES].dq;
        w_qph        = w_dph[DIV_STAGES].dq;
        w_pth        = w_qth[31:0];
        w_pph        = w_qph[31:0] - 32'h4000_0000;
        w_zth        = 62'(w_pth[29:0]) * 62'(PI_Q30);
        w_zph        = 62'(w_pph[29:0]) * 62'(PI_Q30);
        w_u26        = w_qth[41:16];
        w_v27        = w_qph[41:15];
        n_tail0.corn = r_cs[DIV_STAGES-1];
        n_tail0.u    = (w_u26 > 26'd65536) ? 17'd65536 : w_u26[16:0];
        n_tail0.v    = (w_v27 > 27'd65536) ? 17'd65536 : w_v27[16:0];
        n_tail0.qth  = w_pth[31:30];
        n_tail0.qph  = w_pph[31:30];
    end

    logic  r_va;
    t_rot  r_rth0, r_rph0;
    t_tail r_tail0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= w_dv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rth0  <= '{x: CORDIC_INV_GAIN, y: '0, z: $signed({2'b00, w_zth[61:31]})};
            r_rph0  <= '{x: CORDIC_INV_GAIN, y: '0, z: $signed({2'b00, w_zph[61:31]})};
            r_tail0 <= n_tail0;
        end
    end

    // cordic row
    logic  w_cv  [CORDIC_STAGES+1];
    t_rot  w_cth [CORDIC_STAGES+1];
    t_rot  w_cph [CORDIC_STAGES+1];
    t_tail r_ts  [CORDIC_STAGES];

    assign w_cv[0]  = r_va;
    assign w_cth[0] = r_rth0;
    assign w_cph[0] = r_rph0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        uvs_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_k     (5'(g)),
            .i_th    (w_cth[g]),
            .i_ph    (w_cph[g]),
            .o_valid (w_cv[g+1]),
            .o_th    (w_cth[g+1]),
            .o_ph    (w_cph[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ts[g] <= (g == 0) ? r_tail0 : r_ts[(g == 0) ? 0 : g-1];
            end
        end
    end

    // clamp and quadrant
    function automatic logic signed [31:0] f_clamp(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic t_sc f_quad(input t_rot a, input logic [1:0] q);
        logic signed [31:0] x, y;
        t_sc                r;
        x = f_clamp(a.x);
        y = f_clamp(a.y);
        unique case (q)
            2'd0: begin r.c = x;  r.s = y;  end
            2'd1: begin r.c = -y; r.s = x;  end
            2'd2: begin r.c = -x; r.s = -y; end
            default: begin r.c = y; r.s = -x; end
        endcase
        return r;
    endfunction

    logic  r_vq;
    t_sc   r_scth, r_scph;
    t_tail r_tq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (w_en) begin
            r_vq <= w_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scth <= f_quad(w_cth[CORDIC_STAGES], r_ts[CORDIC_STAGES-1].qth);
            r_scph <= f_quad(w_cph[CORDIC_STAGES], r_ts[CORDIC_STAGES-1].qph);
            r_tq   <= r_ts[CORDIC_STAGES-1];
        end
    end

    // normal products
    logic               r_vp;
    logic signed [63:0] r_pcc, r_pcs;
    logic signed [31:0] r_nyp;
    t_tail              r_tp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (w_en) begin
            r_vp <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pcc <= 64'(r_scph.c) * 64'(r_scth.c);
            r_pcs <= 64'(r_scph.c) * 64'(r_scth.s);
            r_nyp <= r_scph.s;
            r_tp  <= r_tq;
        end
    end

    // normal rounding
    logic               r_vn;
    logic signed [31:0] r_nx, r_ny, r_nz;
    t_tail              r_tn;
    logic signed [63:0] w_rx, w_rz;

    assign w_rx = (r_pcc + 64'sd536870912) >>> 30;
    assign w_rz = (64'sd536870912 - r_pcs) >>> 30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else if (w_en) begin
            r_vn <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx <= 32'(w_rx);
            r_ny <= r_nyp;
            r_nz <= 32'(w_rz);
            r_tn <= r_tp;
        end
    end

    // radius products and normal output
    function automatic logic signed [15:0] f_norm(input logic signed [31:0] n);
        logic signed [31:0] t;
        logic signed [15:0] r;
        t = (n + 32'sd32768) >>> 16;
        if (t > 32'sd16384) begin
            r = 16'sd16384;
        end else if (t < -32'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = 16'(t);
        end
        return r;
    endfunction

    logic               r_vr;
    logic signed [63:0] r_prx, r_pry, r_prz;
    logic signed [15:0] r_gx, r_gy, r_gz;
    t_tail              r_tr;
    logic signed [63:0] w_rad;

    assign w_rad = $signed({33'b0, r_rad});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (w_en) begin
            r_vr <= r_vn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prx <= w_rad * 64'(r_nx);
            r_pry <= w_rad * 64'(r_ny);
            r_prz <= w_rad * 64'(r_nz);
            r_gx  <= f_norm(r_nx);
            r_gy  <= f_norm(r_ny);
            r_gz  <= f_norm(r_nz);
            r_tr  <= r_tn;
        end
    end

    // position add with saturation
    function automatic logic signed [31:0] f_place(input logic signed [31:0] c,
                                                   input logic signed [63:0] p);
        logic signed [63:0] s;
        logic signed [31:0] r;
        s = 64'(c) + ((p + 64'sd536870912) >>> 30);
        if (s > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (s < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'(s);
        end
        return r;
    endfunction

    t_vertex w_push_data;
    logic    w_push;

    always_comb begin
        w_push_data.pos_x    = f_place(r_cx, r_prx);
        w_push_data.pos_y    = f_place(r_cy, r_pry);
        w_push_data.pos_z    = f_place(r_cz, r_prz);
        w_push_data.norm_x   = r_gx;
        w_push_data.norm_y   = r_gy;
        w_push_data.norm_z   = r_gz;
        w_push_data.tex_u    = r_tr.u;
        w_push_data.tex_v    = r_tr.v;
        w_push_data.corner_a = r_tr.corn.a;
        w_push_data.corner_b = r_tr.corn.b;
        w_push_data.corner_c = r_tr.corn.c;
        w_push_data.corner_d = r_tr.corn.d;
    end

    assign w_push = w_en & r_vr;

    // output register and skid entry
    t_vertex r_out, r_skid;
    logic    w_take;

    assign w_take = r_out_valid & m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            r_out <= r_skid_valid ? r_skid : w_push_data;
        end else if (w_push) begin
            r_skid <= w_push_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a beat while the output is empty");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_tready) |=> r_skid_valid)
        else $error("skid beat lost while the receiver stalls");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && r_out_valid && !m_tready) |=> !s_tready)
        else $error("row advanced while both output entries were full");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.norm_y <= 16'sd16384 && r_out.norm_y >= -16'sd16384))
        else $error("normal y outside the unit range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && s_tready))
        else $error("output not empty after reset");

endmodule
